// File: rtl/core/handle_registry_table_macros.svh
// Assertion macros for the handle registry table.
// Taken in by the top level; depends on nothing else.
`ifndef HANDLE_REGISTRY_TABLE_MACROS_SVH
`define HANDLE_REGISTRY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/hrt_pkg.sv
// Shared constants and types for the handle registry table.
// No dependencies; used by hrt_scan and handle_registry_table.
package hrt_pkg;

   localparam int SLOTS_DEF       = 64;
   localparam int HANDLE_BITS_DEF = 16;
   localparam int STATUS_W        = 3;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

   // Scanner to top level: finished item waiting to be taken.
   typedef struct packed {
      logic                done;
      logic [STATUS_W-1:0] status;
   } res_type;

endpackage

// File: rtl/core/hrt_ram.sv
// Generic single-port RAM with registered read data (read-first).
// No dependencies.
module hrt_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/hrt_scan.sv
// Slot scanner: walks the slot memory below the high-water mark, looks for a
// match and the first free slot, then writes back. Uses hrt_pkg and hrt_ram.
module hrt_scan #(
   parameter int SLOTS       = hrt_pkg::SLOTS_DEF,
   parameter int HANDLE_BITS = hrt_pkg::HANDLE_BITS_DEF,
   localparam int IW = $clog2(SLOTS),
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [HANDLE_BITS-1:0] req_handle,
   input  logic [CW-1:0]          extent,
   output hrt_pkg::res_type       res,
   output logic [IW-1:0]          res_slot,
   input  logic                   res_take
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_READ    = 5'b00010,
      S_CHECK   = 5'b00100,
      S_RESOLVE = 5'b01000,
      S_DONE    = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic                           op_ff, op_in;
   logic [HANDLE_BITS-1:0]         handle_ff, handle_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic                           free_hit_ff, free_hit_in;
   logic [IW-1:0]                  free_idx_ff, free_idx_in;
   logic [hrt_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [IW-1:0]                  slot_ff, slot_in;

   logic                   ram_we;
   logic [IW-1:0]          ram_addr;
   logic [HANDLE_BITS:0]   ram_wdata;
   logic [HANDLE_BITS:0]   ram_rdata;
   logic                   rd_used;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [CW-1:0]          idx_cnt;

   // Entries below the high-water mark have all been written, so the memory
   // needs no clearing: the used flag sits in the top bit of each word.
   hrt_ram #(
      .WIDTH (HANDLE_BITS + 1),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rd_used   = ram_rdata[HANDLE_BITS];
   assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
   assign idx_cnt   = CW'(idx_ff) + CW'(1);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      handle_in   = handle_ff;
      idx_in      = idx_ff;
      free_hit_in = free_hit_ff;
      free_idx_in = free_idx_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;
      ram_we      = 1'b0;
      ram_addr    = idx_ff;
      ram_wdata   = {1'b1, handle_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               handle_in   = req_handle;
               idx_in      = '0;
               free_hit_in = 1'b0;
               state_in    = (extent == '0) ? S_RESOLVE : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rd_used && (rd_handle == handle_ff)) begin
               slot_in = idx_ff;
               if (op_ff == hrt_pkg::OP_ADD) begin
                  status_in = hrt_pkg::ST_PRESENT;
               end else begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, handle_ff};
                  status_in = hrt_pkg::ST_REMOVED;
               end
               state_in = S_DONE;
            end else begin
               if (!rd_used && !free_hit_ff) begin
                  free_hit_in = 1'b1;
                  free_idx_in = idx_ff;
               end
               if (idx_cnt == extent) begin
                  state_in = S_RESOLVE;
               end else begin
                  idx_in   = idx_cnt[IW-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_RESOLVE: begin
            slot_in = '0;
            if (op_ff == hrt_pkg::OP_DELETE) begin
               status_in = hrt_pkg::ST_NOTFOUND;
            end else if (free_hit_ff) begin
               ram_we    = 1'b1;
               ram_addr  = free_idx_ff;
               slot_in   = free_idx_ff;
               status_in = hrt_pkg::ST_REUSED;
            end else if (extent < CW'(SLOTS)) begin
               ram_we    = 1'b1;
               ram_addr  = extent[IW-1:0];
               slot_in   = extent[IW-1:0];
               status_in = hrt_pkg::ST_APPENDED;
            end else begin
               status_in = hrt_pkg::ST_FULL;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff       <= op_in;
      handle_ff   <= handle_in;
      idx_ff      <= idx_in;
      free_hit_ff <= free_hit_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      slot_ff     <= slot_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign res.done   = (state_ff == S_DONE);
   assign res.status = status_ff;
   assign res_slot   = slot_ff;

endmodule

// File: rtl/core/handle_registry_table.sv
// Handle registry table. A request is scanned over the slots below the
// high-water mark; each slot scanned takes an address state, then a compare
// state, on the single memory port. A new request can be taken in the same
// cycle that the result is first held in the output register.
// Reset clears counters, largest handle and control; the slot memory needs no
// clearing since only slots below the high-water mark are ever read.
`include "handle_registry_table_macros.svh"

module handle_registry_table #(
   parameter int SLOTS       = hrt_pkg::SLOTS_DEF,
   parameter int HANDLE_BITS = hrt_pkg::HANDLE_BITS_DEF,
   localparam int IW = $clog2(SLOTS),
   localparam int CW = $clog2(SLOTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [HANDLE_BITS-1:0]       req_handle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hrt_pkg::STATUS_W-1:0] rsp_status,
   output logic [IW-1:0]                rsp_slot_index,
   output logic [CW-1:0]                rsp_live_count,
   output logic [CW-1:0]                rsp_high_water,
   output logic [HANDLE_BITS-1:0]       rsp_largest_handle,
   output logic                         rsp_largest_valid
);

   hrt_pkg::res_type res;
   logic [IW-1:0]    res_slot;
   logic             res_take;
   logic             done_xfer;
   logic             req_xfer;

   logic [CW-1:0]          live_ff, live_in;
   logic [CW-1:0]          extent_ff, extent_in;
   logic [HANDLE_BITS-1:0] max_ff, max_in;
   logic                   maxv_ff, maxv_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [hrt_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [IW-1:0]                rsp_slot_ff;
   logic [CW-1:0]                rsp_live_ff;
   logic [CW-1:0]                rsp_extent_ff;
   logic [HANDLE_BITS-1:0]       rsp_max_ff;
   logic                         rsp_maxv_ff;

   hrt_scan #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_handle (req_handle),
      .extent     (extent_ff),
      .res        (res),
      .res_slot   (res_slot),
      .res_take   (res_take)
   );

   assign res_take  = !rsp_valid_ff || rsp_ready;
   assign done_xfer = res.done && res_take;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      live_in   = live_ff;
      extent_in = extent_ff;
      max_in    = max_ff;
      maxv_in   = maxv_ff;

      // largest handle moves on transfer of an add; only one item is ever in the scanner
      if (req_xfer && (req_op == hrt_pkg::OP_ADD)) begin
         if (!maxv_ff || (req_handle > max_ff)) begin
            max_in = req_handle;
         end
         maxv_in = 1'b1;
      end

      if (done_xfer) begin
         case (res.status) inside
            hrt_pkg::ST_REUSED: begin
               live_in = live_ff + CW'(1);
            end
            hrt_pkg::ST_APPENDED: begin
               live_in   = live_ff + CW'(1);
               extent_in = extent_ff + CW'(1);
            end
            hrt_pkg::ST_REMOVED: begin
               if (live_ff != '0) begin
                  live_in = live_ff - CW'(1);
               end
            end
            default: begin
               live_in = live_ff;
            end
         endcase
      end

      if (done_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         extent_ff    <= '0;
         max_ff       <= '0;
         maxv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         extent_ff    <= extent_in;
         max_ff       <= max_in;
         maxv_ff      <= maxv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done_xfer) begin
         rsp_status_ff <= res.status;
         rsp_slot_ff   <= res_slot;
         rsp_live_ff   <= live_in;
         rsp_extent_ff <= extent_in;
         rsp_max_ff    <= max_ff;
         rsp_maxv_ff   <= maxv_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_live_count     = rsp_live_ff;
   assign rsp_high_water     = rsp_extent_ff;
   assign rsp_largest_handle = rsp_max_ff;
   assign rsp_largest_valid  = rsp_maxv_ff;

   `HRT_ASSERT_IMPL(a_live_within_extent, clock, reset, 1'b1, live_ff <= extent_ff, "live count above high-water mark")
   `HRT_ASSERT_IMPL(a_extent_within_slots, clock, reset, 1'b1, extent_ff <= CW'(SLOTS), "high-water mark beyond table")
   `HRT_ASSERT_IMPL(a_extent_no_shrink, clock, reset, !$past(reset), extent_ff >= $past(extent_ff), "high-water mark shrank")
   `HRT_ASSERT_NEXT(a_result_loaded, clock, reset, done_xfer, rsp_valid_ff && req_ready, "finished item not delivered")

endmodule
